// ===== rtl/core/lbp_pkg.sv =====
package lbp_pkg;

  localparam int VAL_W  = 17;
  localparam int GAIN_W = 16;
  localparam int PROD_W = VAL_W + GAIN_W;
  localparam int CONE_W = PROD_W - 8;
  localparam int SUM_W  = CONE_W + 1;

  localparam logic [VAL_W-1:0]  ONE_Q16    = 17'h10000;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;

  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } lbp_cmd_t;

endpackage

// ===== rtl/core/lbp_ctrl.sv =====
module lbp_ctrl
  import lbp_pkg::*;
#(
  parameter int TABLE_CAPACITY = 128,
  parameter int IDX_W          = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  output lbp_cmd_t         cmd,
  output logic [IDX_W-1:0] scan_idx
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DRAIN1 = 3'd2;
  localparam logic [2:0] ST_DRAIN2 = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0]       state, state_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic             idx_last;

  assign idx_last = (idx == IDX_W'(TABLE_CAPACITY - 1));

  always_comb begin
    state_next = state;
    idx_next   = idx;
    unique case (state)
      ST_IDLE: begin
        idx_next = '0;
        if (start) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        idx_next = idx + 1'b1;
        if (idx_last) state_next = ST_DRAIN1;
      end
      ST_DRAIN1: state_next = ST_DRAIN2;
      ST_DRAIN2: state_next = ST_FINISH;
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  assign busy       = (state != ST_IDLE);
  assign cmd.load   = start && (state == ST_IDLE);
  assign cmd.scan   = (state == ST_SCAN);
  assign cmd.finish = (state == ST_FINISH);
  assign scan_idx   = idx;

endmodule

// ===== rtl/core/lbp_datapath.sv =====
module lbp_datapath
  import lbp_pkg::*;
#(
  parameter int TABLE_CAPACITY = 128,
  parameter int IDX_W          = 7,
  parameter int CNT_W          = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  lbp_cmd_t          cmd,
  input  logic [IDX_W-1:0]  scan_idx,
  input  logic              cfg_valid,
  input  logic [GAIN_W-1:0] cfg_data,
  input  logic [VAL_W-1:0]  context_req,
  input  logic [VAL_W-1:0]  buyer_value,
  output logic              done,
  output logic [VAL_W-1:0]  price,
  output logic [VAL_W-1:0]  upper_bound,
  output logic [VAL_W-1:0]  lower_bound,
  output logic              sold,
  output logic              dropped
);

  localparam int ENT_W = 2 * VAL_W;

  logic [ENT_W-1:0] rej_mem [TABLE_CAPACITY];
  logic [ENT_W-1:0] acc_mem [TABLE_CAPACITY];

  logic [GAIN_W-1:0] gain;
  logic [VAL_W-1:0]  x, v;
  logic [VAL_W-1:0]  ub, lb;
  logic [CNT_W-1:0]  rej_count, acc_count;

  logic [ENT_W-1:0]  rej_rd, acc_rd;
  logic              rej_s1, acc_s1, rej_s2, acc_s2;
  logic [PROD_W-1:0] rej_prod, acc_prod;
  logic [VAL_W-1:0]  rej_p2, acc_p2;

  logic [VAL_W-1:0]  rej_pos, acc_pos, rej_d, acc_d;
  logic [CONE_W-1:0] rej_cone, acc_cone;
  logic [SUM_W-1:0]  rej_t, acc_lim;
  logic [VAL_W:0]    mid_sum;
  logic [VAL_W-1:0]  price_c;
  logic              sold_c, rej_room, acc_room;
  logic [CNT_W-1:0]  scan_ext;

  always_ff @(posedge clk) begin
    if (rst) gain <= GAIN_RESET;
    else if (cfg_valid) gain <= cfg_data;
  end

  assign scan_ext = CNT_W'(scan_idx);

  // stage 1: table read
  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rej_rd <= rej_mem[scan_idx];
      acc_rd <= acc_mem[scan_idx];
    end
    if (cmd.finish && !sold_c && rej_room)
      rej_mem[rej_count[IDX_W-1:0]] <= {x, price_c};
    if (cmd.finish && sold_c && acc_room)
      acc_mem[acc_count[IDX_W-1:0]] <= {x, price_c};
  end

  // stage 2: distance times gain
  assign rej_pos = rej_rd[ENT_W-1:VAL_W];
  assign acc_pos = acc_rd[ENT_W-1:VAL_W];
  assign rej_d   = (rej_pos > x) ? (rej_pos - x) : (x - rej_pos);
  assign acc_d   = (acc_pos > x) ? (acc_pos - x) : (x - acc_pos);

  always_ff @(posedge clk) begin
    rej_prod <= PROD_W'(gain) * PROD_W'(rej_d);
    acc_prod <= PROD_W'(gain) * PROD_W'(acc_d);
    rej_p2   <= rej_rd[VAL_W-1:0];
    acc_p2   <= acc_rd[VAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rej_s1 <= 1'b0;
      acc_s1 <= 1'b0;
      rej_s2 <= 1'b0;
      acc_s2 <= 1'b0;
    end else begin
      rej_s1 <= cmd.scan && (scan_ext < rej_count);
      acc_s1 <= cmd.scan && (scan_ext < acc_count);
      rej_s2 <= rej_s1;
      acc_s2 <= acc_s1;
    end
  end

  // stage 3: bound update
  assign rej_cone = rej_prod[PROD_W-1:8];
  assign acc_cone = acc_prod[PROD_W-1:8];
  assign rej_t    = SUM_W'(rej_p2) + SUM_W'(rej_cone);
  assign acc_lim  = SUM_W'(lb) + SUM_W'(acc_cone);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x  <= context_req;
      v  <= buyer_value;
      ub <= ONE_Q16;
      lb <= '0;
    end else begin
      if (rej_s2 && (rej_t < SUM_W'(ub))) ub <= rej_t[VAL_W-1:0];
      if (acc_s2 && (SUM_W'(acc_p2) > acc_lim)) lb <= acc_p2 - acc_cone[VAL_W-1:0];
    end
  end

  assign mid_sum  = {1'b0, ub} + {1'b0, lb};
  assign price_c  = mid_sum[VAL_W:1];
  assign sold_c   = !(price_c > v);
  assign rej_room = (rej_count < CNT_W'(TABLE_CAPACITY));
  assign acc_room = (acc_count < CNT_W'(TABLE_CAPACITY));

  always_ff @(posedge clk) begin
    if (rst) begin
      rej_count <= '0;
      acc_count <= '0;
      done      <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.finish && !sold_c && rej_room) rej_count <= rej_count + 1'b1;
      if (cmd.finish && sold_c && acc_room) acc_count <= acc_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      price       <= price_c;
      upper_bound <= ub;
      lower_bound <= lb;
      sold        <= sold_c;
      dropped     <= sold_c ? !acc_room : !rej_room;
    end
  end

endmodule

// ===== rtl/core/lipschitz_bound_pricing_unit.sv =====
// Sequence: after the accepting edge the controller runs SCAN, DRAIN1, DRAIN2
// and FINISH; done is registered from FINISH, together with the result.
// A new request is accepted only while busy is low; both tables are read
// one entry per cycle through one read port each, in parallel.
// Reset: gain 256, both table counts cleared, table contents undefined.
// done is high for exactly one cycle; the receiver cannot stall it.
module lipschitz_bound_pricing_unit
  import lbp_pkg::*;
#(
  parameter int TABLE_CAPACITY = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [VAL_W-1:0]  context_req,
  input  logic [VAL_W-1:0]  buyer_value,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [GAIN_W-1:0] cfg_data,
  output logic              done,
  output logic [VAL_W-1:0]  price,
  output logic [VAL_W-1:0]  upper_bound,
  output logic [VAL_W-1:0]  lower_bound,
  output logic              sold,
  output logic              dropped
);

  localparam int IDX_W = (TABLE_CAPACITY > 1) ? $clog2(TABLE_CAPACITY) : 1;
  localparam int CNT_W = $clog2(TABLE_CAPACITY + 1);

  lbp_cmd_t         cmd;
  logic [IDX_W-1:0] scan_idx;

  assign cfg_ready = 1'b1;

  lbp_ctrl #(
    .TABLE_CAPACITY(TABLE_CAPACITY),
    .IDX_W         (IDX_W)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .cmd     (cmd),
    .scan_idx(scan_idx)
  );

  lbp_datapath #(
    .TABLE_CAPACITY(TABLE_CAPACITY),
    .IDX_W         (IDX_W),
    .CNT_W         (CNT_W)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .scan_idx   (scan_idx),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .context_req(context_req),
    .buyer_value(buyer_value),
    .done       (done),
    .price      (price),
    .upper_bound(upper_bound),
    .lower_bound(lower_bound),
    .sold       (sold),
    .dropped    (dropped)
  );

endmodule
